// ----- src/tfcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_pkg
// Shared types, operation codes and palette tables of the formatting-code
// parser.
// ----------------------------------------------------------------------------
package tfcp_pkg;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [3:0] COLOR_DEFAULT = 4'hF;
  localparam logic [4:0] FLAGS_DEFAULT = 5'b00000;

  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_R   = 8'h72;
  localparam logic [7:0] CHAR_K   = 8'h6B;

  typedef logic [1:0] op_t;
  localparam op_t OP_NOP  = 2'd0;
  localparam op_t OP_CHAR = 2'd1;
  localparam op_t OP_END  = 2'd2;
  localparam op_t OP_CODE = 2'd3;

  typedef logic [1:0] code_t;
  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_COLOR = 2'd1;
  localparam code_t CODE_FLAG  = 2'd2;
  localparam code_t CODE_CLEAR = 2'd3;

  typedef struct packed {
    logic       start;
    op_t        op;
    code_t      code_kind;
    logic [3:0] code_arg;
    logic [7:0] char_byte;
  } q_entry_t;

  function automatic logic [31:0] pal_bright(input logic [3:0] c);
    logic [31:0] v;
    case (c)
      4'd0:    v = 32'h000000FF;
      4'd1:    v = 32'h0000AAFF;
      4'd2:    v = 32'h00AA00FF;
      4'd3:    v = 32'h00AAAAFF;
      4'd4:    v = 32'hAA0000FF;
      4'd5:    v = 32'hAA00AAFF;
      4'd6:    v = 32'hFFAA00FF;
      4'd7:    v = 32'hAAAAAAFF;
      4'd8:    v = 32'h555555FF;
      4'd9:    v = 32'h5555FFFF;
      4'd10:   v = 32'h55FF55FF;
      4'd11:   v = 32'h55FFFFFF;
      4'd12:   v = 32'hFF5555FF;
      4'd13:   v = 32'hFF55FFFF;
      4'd14:   v = 32'hFFFF55FF;
      default: v = 32'hFFFFFFFF;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pal_dark(input logic [3:0] c);
    logic [31:0] v;
    case (c)
      4'd0:    v = 32'h000000FF;
      4'd1:    v = 32'h00002AFF;
      4'd2:    v = 32'h002A00FF;
      4'd3:    v = 32'h002A2AFF;
      4'd4:    v = 32'h2A0000FF;
      4'd5:    v = 32'h2A002AFF;
      4'd6:    v = 32'h2A2A00FF;
      4'd7:    v = 32'h2A2A2AFF;
      4'd8:    v = 32'h151515FF;
      4'd9:    v = 32'h15153FFF;
      4'd10:   v = 32'h153F15FF;
      4'd11:   v = 32'h153F3FFF;
      4'd12:   v = 32'h3F1515FF;
      4'd13:   v = 32'h3F153FFF;
      4'd14:   v = 32'h3F3F15FF;
      default: v = 32'h3F3F3FFF;
    endcase
    return v;
  endfunction

endpackage

// ----- src/tfcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_front
// Accepts text bytes, tracks the pending-code flag and classifies each byte
// into an operation for the back end.
// ----------------------------------------------------------------------------
module tfcp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  input  logic               string_start,
  output logic               push,
  output tfcp_pkg::q_entry_t push_entry,
  input  logic               q_full
);
  import tfcp_pkg::*;

  logic pending;
  logic pending_next;
  logic pend_eff;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;
  assign pend_eff = pending && !string_start;

  always_comb begin
    push_entry.start     = string_start;
    push_entry.char_byte = text_byte;
    push_entry.code_kind = CODE_NONE;
    push_entry.code_arg  = 4'd0;
    push_entry.op        = OP_CHAR;
    pending_next         = pend_eff;
    if (text_byte == CHAR_NUL) begin
      push_entry.op = OP_END;
      pending_next  = 1'b0;
    end else if (text_byte == CHAR_AMP) begin
      push_entry.op = OP_NOP;
      pending_next  = 1'b1;
    end else if (pend_eff) begin
      push_entry.op = OP_CODE;
      pending_next  = 1'b0;
      // code byte decode
      if (text_byte inside {[8'h30:8'h39]}) begin
        push_entry.code_kind = CODE_COLOR;
        push_entry.code_arg  = text_byte[3:0];
      end else if (text_byte inside {[8'h61:8'h66]}) begin
        push_entry.code_kind = CODE_COLOR;
        push_entry.code_arg  = 4'(text_byte[3:0] + 4'd9);
      end else if (text_byte inside {[8'h6B:8'h6F]}) begin
        push_entry.code_kind = CODE_FLAG;
        push_entry.code_arg  = 4'(text_byte - CHAR_K);
      end else if (text_byte == CHAR_R) begin
        push_entry.code_kind = CODE_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
    end
  end

endmodule

// ----- src/tfcp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_fifo
// Short queue of classified operations between front and back end.
// ----------------------------------------------------------------------------
module tfcp_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tfcp_pkg::q_entry_t push_entry,
  output logic               q_full,
  input  logic               pop,
  output logic               q_valid,
  output tfcp_pkg::q_entry_t head
);
  import tfcp_pkg::*;

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      count <= QCNT_W'(count + QCNT_W'(push) - QCNT_W'(pop));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- src/tfcp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_back
// Holds the current format, carries out queued operations and drives the
// registered result word.
// ----------------------------------------------------------------------------
module tfcp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tfcp_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic [3:0]         color_index,
  output logic [4:0]         style_flags,
  output logic [31:0]        fg_rgba,
  output logic [31:0]        bg_rgba,
  output logic               end_of_string
);
  import tfcp_pkg::*;

  logic [3:0] color;
  logic [4:0] flags;
  logic [3:0] color_base;
  logic [4:0] flags_base;
  logic [3:0] color_next;
  logic [4:0] flags_next;
  logic       emit;
  logic [3:0] res_color;

  assign pop  = q_valid && (!out_valid || !out_stall);
  assign emit = (head.op == OP_CHAR) || (head.op == OP_END);

  assign color_base = head.start ? COLOR_DEFAULT : color;
  assign flags_base = head.start ? FLAGS_DEFAULT : flags;
  assign res_color  = (head.op == OP_END) ? 4'd0 : color_base;

  always_comb begin
    color_next = color_base;
    flags_next = flags_base;
    if (head.op == OP_CODE) begin
      case (head.code_kind)
        CODE_COLOR: color_next = head.code_arg;
        CODE_FLAG:  flags_next = flags_base | (5'b00001 << head.code_arg[2:0]);
        CODE_CLEAR: flags_next = FLAGS_DEFAULT;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_DEFAULT;
      flags <= FLAGS_DEFAULT;
    end else if (pop) begin
      color <= color_next;
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_char      <= head.char_byte;
      color_index   <= res_color;
      style_flags   <= (head.op == OP_END) ? 5'd0 : flags_base;
      fg_rgba       <= pal_bright(res_color);
      bg_rgba       <= pal_dark(res_color);
      end_of_string <= (head.op == OP_END);
    end
  end

  // code words never produce a result
  a_code_silent: assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == OP_CODE && !out_valid) |=> !out_valid)
    else $error("code word produced a result");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (color_index == 4'd0 && style_flags == 5'd0))
    else $error("end word with nonzero format");

  a_start_default: assert property (@(posedge clk) disable iff (rst)
    (pop && head.start && head.op == OP_NOP) |=>
      (color == COLOR_DEFAULT && flags == FLAGS_DEFAULT))
    else $error("string start did not restore default format");

endmodule

// ----- src/text_format_code_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_format_code_parser_core
// Parses ampersand formatting codes in a byte stream and emits characters
// with their colour, style flags and palette colours.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : in_valid / in_stall with text_byte and string_start; one
//                   word per byte of text, string_start on the first byte
//   output channel: out_valid / out_stall with out_char, color_index,
//                   style_flags, fg_rgba, bg_rgba and end_of_string
//   '&' and the code byte after it produce no output word; byte 0 produces
//   an end word with zeroed format
//   path: the accepted byte is written into the queue, then into the output
//   register when the back end pops it; a held output word or earlier
//   queued bytes keep it waiting in the queue
//   throughput: 1 byte per cycle while the output is not held by out_stall;
//   the back end updates the format register on every pop
//   reset: format returns to colour 15 with no flags, pending code and the
//   queue are cleared, out_valid drops
//   out_stall holds the output word; the 2-entry queue absorbs the next
//   bytes, then in_stall rises while the queue is full
// ----------------------------------------------------------------------------
module text_format_code_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        string_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic [3:0]  color_index,
  output logic [4:0]  style_flags,
  output logic [31:0] fg_rgba,
  output logic [31:0] bg_rgba,
  output logic        end_of_string
);
  import tfcp_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  q_entry_t push_entry;
  q_entry_t head;

  tfcp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .string_start (string_start),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  tfcp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  tfcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .color_index   (color_index),
    .style_flags   (style_flags),
    .fg_rgba       (fg_rgba),
    .bg_rgba       (bg_rgba),
    .end_of_string (end_of_string)
  );

endmodule
